/* rtl/core/gtg_pkg.sv */
// Shared constants, types and the arctangent table for the go-to-goal controller.
// No dependencies.
package gtg_pkg;

    // CORDIC datapath widths (vector components and Q.20 angle)
    localparam int XW = 44;
    localparam int ZW = 26;

    localparam int CORDIC_ITERS = 16;

    // Angle constants
    localparam logic signed [ZW-1:0] PI_Q20      = 26'sd3294199;
    localparam logic signed [ZW-1:0] TWO_PI_Q20  = 26'sd6588398;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 26'sd1647099;
    localparam logic signed [16:0]   PI_Q13      = 17'sd25736;
    localparam logic signed [16:0]   TWO_PI_Q13  = 17'sd51472;

    // 1/K in Q0.30
    localparam logic [29:0] GAIN_INV_Q30 = 30'd652032875;

    // Request actions
    localparam logic [1:0] ACT_POSE   = 2'd0;
    localparam logic [1:0] ACT_GOAL   = 2'd1;
    localparam logic [1:0] ACT_HAZARD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADING_GAIN = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] REG_ARRIVAL_THR  = 2'd2;

    // Command to the shared CORDIC unit
    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_cmd;

    // atan(2^-i) in Q.20
    function automatic logic [19:0] f_atan(input logic [4:0] idx);
        logic [19:0] v;
        case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/gtg_sqrt.sv */
// Iterative integer square root of a^2 + b^2, two radicand bits per cycle.
// Depends on gtg_pkg.
module gtg_sqrt
    import gtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_a,
    input  logic [30:0] i_b,
    output logic        o_done,
    output logic [31:0] o_root
);

    typedef enum logic [1:0] {Q_IDLE, Q_SQA, Q_SQB, Q_ITER} t_qstate;

    t_qstate     r_state;
    logic [30:0] r_a, r_b;
    logic [63:0] r_n;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_done;

    logic [34:0] n_rem_sh, n_trial;

    // one restoring step
    always_comb begin
        n_rem_sh = {r_rem[32:0], r_n[63:62]};
        n_trial  = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                Q_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_state <= Q_SQA;
                    end
                end
                Q_SQA: begin
                    r_n     <= {2'b00, 62'(r_a) * 62'(r_a)};
                    r_state <= Q_SQB;
                end
                Q_SQB: begin
                    r_n     <= r_n + {2'b00, 62'(r_b) * 62'(r_b)};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= Q_ITER;
                end
                Q_ITER: begin
                    if (n_rem_sh >= n_trial) begin
                        r_rem  <= n_rem_sh - n_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_n   <= {r_n[61:0], 2'b00};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_done  <= 1'b1;
                        r_state <= Q_IDLE;
                    end
                end
                default: r_state <= Q_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/core/gtg_cordic.sv */
// Shared CORDIC unit: vectoring (with pre-normalisation) or rotation, one step a cycle.
// Depends on gtg_pkg.
module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int ITERS = CORDIC_ITERS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_cmd          i_cmd,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    localparam int IW = $clog2(ITERS);
    localparam logic [IW-1:0] LAST = IW'(ITERS - 1);
    localparam logic signed [XW-1:0] NORM_LIM = XW'(64'sd1 <<< 39);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    t_cstate              r_state;
    logic                 r_vec;
    logic [IW-1:0]        r_i;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_done;

    logic signed [XW-1:0] n_xs, n_ys, n_ay;
    logic signed [ZW-1:0] n_at;
    logic                 n_up;

    // shifted terms and step direction
    always_comb begin
        n_xs = r_x >>> r_i;
        n_ys = r_y >>> r_i;
        n_at = $signed({6'b0, f_atan(5'(r_i))});
        n_up = r_vec ? ~r_y[XW-1] : r_z[ZW-1];
        n_ay = r_y[XW-1] ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_cmd.start) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_z     <= i_z;
                        r_vec   <= i_cmd.vectoring;
                        r_i     <= '0;
                        r_state <= i_cmd.vectoring ? C_NORM : C_ITER;
                    end
                end
                // scale the vector up until one component reaches 2^39
                C_NORM: begin
                    if (r_x < NORM_LIM && n_ay < NORM_LIM) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (n_up) begin
                        r_x <= r_x + n_ys;
                        r_y <= r_y - n_xs;
                        r_z <= r_z + n_at;
                    end else begin
                        r_x <= r_x - n_ys;
                        r_y <= r_y + n_xs;
                        r_z <= r_z - n_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

/* rtl/core/go_to_goal_steering_controller_unit.sv */
// Go-to-goal steering controller: top level sequencer, state and registers.
// Pose request: the square root runs beside the CORDIC (normalisation, then the rotation
// steps), then the speed and turn multiplies (S_PMUL, S_PTURN) and the output step (S_POUT).
// Hazard request: seed multiply (S_HMUL), then a CORDIC rotation; goal request: no result.
// One request at a time; a held result stalls the output step.
// Synchronous active-low reset clears gains to 1.0, threshold to 1 m, goal and count.
module go_to_goal_steering_controller_unit
    import gtg_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic               i_hazard_flag,
    input  logic signed [15:0] i_hazard_angle,
    input  logic [30:0]        i_hazard_distance,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [30:0]        o_linear_speed,
    output logic signed [15:0] o_turn_rate,
    output logic               o_goal_reached,
    output logic [7:0]         o_avoid_level,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_POSE, S_PWAIT, S_PMUL, S_PTURN, S_POUT, S_HMUL, S_HSTART, S_HWAIT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_heading_gain, r_speed_gain;
    logic [30:0] r_arrival_thr;

    // architectural state
    logic signed [31:0] r_goal_x, r_goal_y;
    logic signed [15:0] r_goal_heading, r_cur_heading;
    logic [7:0]         r_avoid;

    // working registers
    logic signed [32:0] r_dx, r_dy;
    logic               r_shift, r_zero, r_sq_f, r_co_f, r_reached, r_flip;
    logic signed [18:0] r_e13;
    logic [48:0]        r_spd_prod;
    logic signed [35:0] r_turn_prod;
    logic signed [15:0] r_ang;
    logic [30:0]        r_dist, r_x0;
    logic signed [ZW-1:0] r_z0;

    // output register
    logic               r_out_valid;
    logic [30:0]        r_out_speed;
    logic signed [15:0] r_out_turn;
    logic               r_out_reached;
    logic [7:0]         r_out_avoid;

    // shared units
    t_cordic_cmd          n_cmd;
    logic signed [XW-1:0] n_cx, n_cy, co_x, co_y;
    logic signed [ZW-1:0] n_cz, co_z;
    logic                 co_done, sq_done, n_sq_start;
    logic [31:0]          sq_root;

    // pose datapath
    logic signed [32:0]   n_ax, n_ay;
    logic [30:0]          n_a, n_b;
    logic signed [XW-1:0] n_dx_w, n_dy_w;
    logic signed [ZW-1:0] n_bear, n_err0, n_err1, n_err2;
    logic [32:0]          n_distl;
    logic signed [27:0]   n_turn_sh;
    logic signed [15:0]   n_turn_sat;
    logic [30:0]          n_spd_sat;

    // hazard datapath
    logic [60:0]          n_gain_prod;
    logic signed [ZW-1:0] n_hz0, n_hz1, n_hz2;
    logic signed [16:0]   n_gh0, n_gh1, n_gh2;
    logic signed [XW-1:0] n_rx, n_ry;
    logic signed [31:0]   n_gx, n_gy;

    logic n_acc;

    assign n_acc       = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // offsets, magnitudes and CORDIC seed for a pose
    always_comb begin
        n_ax   = r_dx[32] ? -r_dx : r_dx;
        n_ay   = r_dy[32] ? -r_dy : r_dy;
        n_a    = (n_ax[31] | n_ax[32]) || (n_ay[31] | n_ay[32]) ? n_ax[31:1] : n_ax[30:0];
        n_b    = (n_ax[31] | n_ax[32]) || (n_ay[31] | n_ay[32]) ? n_ay[31:1] : n_ay[30:0];
        n_dx_w = XW'(r_dx);
        n_dy_w = XW'(r_dy);
    end

    // heading error wrapped in Q.20 (rounded to Q3.13 in S_PMUL), and the root rescaled to distance
    always_comb begin
        n_bear = r_zero ? '0 : co_z;
        n_err0 = n_bear - (ZW'(r_cur_heading) <<< 7);
        n_err1 = (n_err0 >= PI_Q20) ? n_err0 - TWO_PI_Q20 : n_err0;
        n_err2 = (n_err1 < -PI_Q20) ? n_err1 + TWO_PI_Q20 : n_err1;
        n_distl = r_shift ? {sq_root, 1'b0} : {1'b0, sq_root};
    end

    // output saturation
    always_comb begin
        n_spd_sat = (|r_spd_prod[48:39]) ? 31'h7FFF_FFFF : r_spd_prod[38:8];
        n_turn_sh = r_turn_prod[35:8];
        if (n_turn_sh > 28'sd32767)
            n_turn_sat = 16'sh7FFF;
        else if (n_turn_sh < -28'sd32768)
            n_turn_sat = -16'sh8000;
        else
            n_turn_sat = n_turn_sh[15:0];
    end

    // hazard waypoint seed, angle fold and new goal heading
    always_comb begin
        n_gain_prod = r_dist * GAIN_INV_Q30;
        n_hz0 = ZW'(r_ang) <<< 7;
        n_hz1 = (n_hz0 >= PI_Q20) ? n_hz0 - TWO_PI_Q20 : n_hz0;
        n_hz2 = (n_hz1 < -PI_Q20) ? n_hz1 + TWO_PI_Q20 : n_hz1;
        n_gh0 = 17'(r_cur_heading) + 17'(r_ang);
        n_gh1 = (n_gh0 >= PI_Q13) ? n_gh0 - TWO_PI_Q13 : n_gh0;
        n_gh2 = (n_gh1 < -PI_Q13) ? n_gh1 + TWO_PI_Q13 : n_gh1;
        n_rx  = r_flip ? -co_x : co_x;
        n_ry  = r_flip ? -co_y : co_y;
        if (n_rx > XW'(64'sd2147483647))
            n_gx = 32'sh7FFF_FFFF;
        else if (n_rx < -XW'(64'sd2147483648))
            n_gx = -32'sh8000_0000;
        else
            n_gx = n_rx[31:0];
        if (n_ry > XW'(64'sd2147483647))
            n_gy = 32'sh7FFF_FFFF;
        else if (n_ry < -XW'(64'sd2147483648))
            n_gy = -32'sh8000_0000;
        else
            n_gy = n_ry[31:0];
    end

    // unit start commands
    always_comb begin
        n_cmd      = '0;
        n_sq_start = 1'b0;
        n_cx       = '0;
        n_cy       = '0;
        n_cz       = '0;
        case (r_state)
            S_POSE: begin
                n_sq_start    = 1'b1;
                n_cmd.start   = !((r_dx == '0) && (r_dy == '0));
                n_cmd.vectoring = 1'b1;
                if (r_dx[32]) begin
                    n_cx = -n_dx_w;
                    n_cy = -n_dy_w;
                    n_cz = r_dy[32] ? -PI_Q20 : PI_Q20;
                end else begin
                    n_cx = n_dx_w;
                    n_cy = n_dy_w;
                end
            end
            S_HSTART: begin
                n_cmd.start     = 1'b1;
                n_cmd.vectoring = 1'b0;
                n_cx            = XW'({1'b0, r_x0});
                n_cz            = r_z0;
            end
            default: ;
        endcase
    end

    gtg_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd),
        .i_x     (n_cx),
        .i_y     (n_cy),
        .i_z     (n_cz),
        .o_done  (co_done),
        .o_x     (co_x),
        .o_y     (co_y),
        .o_z     (co_z)
    );

    gtg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_sq_start),
        .i_a     (n_a),
        .i_b     (n_b),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_heading_gain <= 16'd256;
            r_speed_gain   <= 16'd256;
            r_arrival_thr  <= 31'd65536;
            r_goal_x       <= '0;
            r_goal_y       <= '0;
            r_goal_heading <= '0;
            r_cur_heading  <= '0;
            r_avoid        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_HEADING_GAIN: r_heading_gain <= i_cfg_data[15:0];
                    REG_SPEED_GAIN:   r_speed_gain   <= i_cfg_data[15:0];
                    REG_ARRIVAL_THR:  r_arrival_thr  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (n_acc) begin
                        case (i_action)
                            ACT_POSE: begin
                                r_dx          <= {r_goal_x[31], r_goal_x} - {i_pos_x[31], i_pos_x};
                                r_dy          <= {r_goal_y[31], r_goal_y} - {i_pos_y[31], i_pos_y};
                                r_cur_heading <= i_heading;
                                r_state       <= S_POSE;
                            end
                            ACT_GOAL: begin
                                if (r_avoid == 8'd0) begin
                                    r_goal_x       <= i_pos_x;
                                    r_goal_y       <= i_pos_y;
                                    r_goal_heading <= i_heading;
                                end
                            end
                            ACT_HAZARD: begin
                                if (i_hazard_flag) begin
                                    r_ang   <= i_hazard_angle;
                                    r_dist  <= i_hazard_distance;
                                    r_state <= S_HMUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_POSE: begin
                    r_shift   <= (n_ax[31] | n_ax[32]) || (n_ay[31] | n_ay[32]);
                    r_zero    <= (r_dx == '0) && (r_dy == '0);
                    r_co_f    <= (r_dx == '0) && (r_dy == '0);
                    r_sq_f    <= 1'b0;
                    r_reached <= (n_ax < $signed({2'b00, r_arrival_thr}))
                              && (n_ay < $signed({2'b00, r_arrival_thr}));
                    if ((n_ax < $signed({2'b00, r_arrival_thr}))
                        && (n_ay < $signed({2'b00, r_arrival_thr})))
                        r_avoid <= '0;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    if (sq_done) r_sq_f <= 1'b1;
                    if (co_done) r_co_f <= 1'b1;
                    if (r_sq_f && r_co_f)
                        r_state <= S_PMUL;
                end
                S_PMUL: begin
                    r_spd_prod <= r_speed_gain * n_distl;
                    r_e13      <= 19'((n_err2 + ZW'(64)) >>> 7);
                    r_state    <= S_PTURN;
                end
                S_PTURN: begin
                    r_turn_prod <= $signed({1'b0, r_heading_gain}) * r_e13;
                    r_state     <= S_POUT;
                end
                S_POUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_speed   <= n_spd_sat;
                        r_out_turn    <= n_turn_sat;
                        r_out_reached <= r_reached;
                        r_out_avoid   <= r_avoid;
                        r_state       <= S_IDLE;
                    end
                end
                S_HMUL: begin
                    r_x0           <= n_gain_prod[60:30];
                    r_goal_heading <= n_gh2[15:0];
                    if (n_hz2 > HALF_PI_Q20) begin
                        r_z0   <= n_hz2 - PI_Q20;
                        r_flip <= 1'b1;
                    end else if (n_hz2 < -HALF_PI_Q20) begin
                        r_z0   <= n_hz2 + PI_Q20;
                        r_flip <= 1'b1;
                    end else begin
                        r_z0   <= n_hz2;
                        r_flip <= 1'b0;
                    end
                    r_state <= S_HSTART;
                end
                S_HSTART: r_state <= S_HWAIT;
                S_HWAIT: begin
                    if (co_done) begin
                        r_goal_x <= n_gx;
                        r_goal_y <= n_gy;
                        if (r_avoid != 8'd255)
                            r_avoid <= r_avoid + 8'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_linear_speed = r_out_speed;
    assign o_turn_rate    = r_out_turn;
    assign o_goal_reached = r_out_reached;
    assign o_avoid_level  = r_out_avoid;

endmodule

/* verif/gtg_checker.sv */
// Checker for the go-to-goal steering controller: watches the request, result and
// register channels, predicts each command and compares it with the block's output.
// Depends on gtg_pkg for the action and register codes.
`timescale 1ns / 1ps
module gtg_checker
    import gtg_pkg::*;
#(
    parameter int ITERS = CORDIC_ITERS
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic               i_hazard_flag,
    input  logic signed [15:0] i_hazard_angle,
    input  logic [30:0]        i_hazard_distance,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [30:0]        o_linear_speed,
    input  logic signed [15:0] o_turn_rate,
    input  logic               o_goal_reached,
    input  logic [7:0]         o_avoid_level,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [30:0]        speed;
        logic signed [15:0] turn;
        logic               reached;
        logic [7:0]         level;
    } t_steer_cmd;

    localparam longint PI20      = 3294199;
    localparam longint TWO_PI20  = 2 * PI20;
    localparam longint HALF_PI20 = 1647099;
    localparam longint PI13      = 25736;
    localparam longint TWO_PI13  = 2 * PI13;
    localparam longint unsigned INV_GAIN30 = 652032875;

    localparam longint ATAN_TBL [0:23] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    // Expected commands, oldest first
    t_steer_cmd cmd_q[$];

    // Predictor registers and state
    longint unsigned heading_gain, speed_gain, arrival_thr;
    longint goal_x, goal_y, goal_hdg, cur_hdg;
    int unsigned avoid_cnt;

    function automatic int n_iters();
        return (ITERS > 24) ? 24 : ITERS;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Bearing of (dx, dy) in Q.20 by CORDIC vectoring
    function automatic longint bearing_of(longint dx, longint dy);
        longint x, y, z, ax, ay, xs, ys;
        x = dx;
        y = dy;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            z = (dy >= 0) ? PI20 : -PI20;
            x = -x;
            y = -y;
        end
        ax = x;
        ay = (y < 0) ? -y : y;
        while (ax < (64'sd1 <<< 39) && ay < (64'sd1 <<< 39)) begin
            x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
        end
        for (int i = 0; i < n_iters(); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end
        end
        return z;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Waypoint at wp_dist along ang by CORDIC rotation
    task automatic place_waypoint(longint ang, longint unsigned wp_dist);
        longint z, x, y, xs, ys;
        bit flip;
        z = ang * 128;
        flip = 0;
        if (z >= PI20) z = z - TWO_PI20;
        if (z < -PI20) z = z + TWO_PI20;
        if (z > HALF_PI20) begin
            z = z - PI20; flip = 1;
        end else if (z < -HALF_PI20) begin
            z = z + PI20; flip = 1;
        end
        x = longint'((wp_dist * INV_GAIN30) >> 30);
        y = 0;
        for (int i = 0; i < n_iters(); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        goal_x = sat(x, -64'sd2147483648, 64'sd2147483647);
        goal_y = sat(y, -64'sd2147483648, 64'sd2147483647);
    endtask

    // Steering command for a pose request; updates heading and avoid count
    task automatic predict_pose(longint px, longint py, longint hd,
                                output t_steer_cmd cmd);
        longint dx, dy, err, e13, turn;
        longint unsigned ax, ay, a, b, dist_v, spd;
        int s;
        bit reached;
        dx = goal_x - px;
        dy = goal_y - py;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
        a = ax >> s;
        b = ay >> s;
        dist_v = int_sqrt(a * a + b * b) << s;
        spd = (speed_gain * dist_v) >> 8;
        if (spd > 64'h7FFF_FFFF) spd = 64'h7FFF_FFFF;
        cur_hdg = hd;
        err = bearing_of(dx, dy) - hd * 128;
        if (err >= PI20) err = err - TWO_PI20;
        if (err < -PI20) err = err + TWO_PI20;
        e13 = (err + 64) >>> 7;
        turn = sat((longint'(heading_gain) * e13) >>> 8, -32768, 32767);
        reached = (ax < arrival_thr) && (ay < arrival_thr);
        if (reached) avoid_cnt = 0;
        cmd.speed   = spd[30:0];
        cmd.turn    = turn[15:0];
        cmd.reached = reached;
        cmd.level   = avoid_cnt[7:0];
    endtask

    always @(posedge i_clk) begin
        t_steer_cmd want, got;
        longint gh;
        if (!i_rst_n) begin
            heading_gain = 256;
            speed_gain   = 256;
            arrival_thr  = 65536;
            goal_x = 0; goal_y = 0; goal_hdg = 0; cur_hdg = 0;
            avoid_cnt = 0;
            cmd_q.delete();
            o_fail_count = 0;
        end else begin
            // Result side
            if (o_valid && i_ready) begin
                got = '{o_linear_speed, o_turn_rate, o_goal_reached, o_avoid_level};
                if (cmd_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected command speed=%0d turn=%0d reached=%0b level=%0d",
                             $time, got.speed, got.turn, got.reached, got.level);
                end else begin
                    want = cmd_q.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: mismatch expected speed=%0d turn=%0d reached=%0b level=%0d",
                                 $time, want.speed, want.turn, want.reached, want.level);
                        $display("%0t:          actual   speed=%0d turn=%0d reached=%0b level=%0d",
                                 $time, got.speed, got.turn, got.reached, got.level);
                    end
                end
            end
            // Register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_HEADING_GAIN: heading_gain = i_cfg_data[15:0];
                    REG_SPEED_GAIN:   speed_gain   = i_cfg_data[15:0];
                    REG_ARRIVAL_THR:  arrival_thr  = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // Request side
            if (i_valid && o_ready) begin
                case (i_action)
                    ACT_POSE: begin
                        predict_pose(i_pos_x, i_pos_y, i_heading, want);
                        cmd_q.push_back(want);
                    end
                    ACT_GOAL: begin
                        if (avoid_cnt == 0) begin
                            goal_x = i_pos_x; goal_y = i_pos_y; goal_hdg = i_heading;
                        end
                    end
                    ACT_HAZARD: begin
                        if (i_hazard_flag) begin
                            gh = cur_hdg + longint'(i_hazard_angle);
                            place_waypoint(i_hazard_angle, i_hazard_distance);
                            if (gh >= PI13) gh = gh - TWO_PI13;
                            if (gh < -PI13) gh = gh + TWO_PI13;
                            goal_hdg = gh;
                            if (avoid_cnt < 255) avoid_cnt++;
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= cmd_q.size();
    end

endmodule

/* verif/go_to_goal_steering_controller_unit_tb.sv */
// Testbench top for the go-to-goal steering controller: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict. Depends on gtg_pkg and gtg_checker.
`timescale 1ns / 1ps
module go_to_goal_steering_controller_unit_tb;
    import gtg_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = ACT_POSE;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [15:0] i_heading = '0;
    logic               i_hazard_flag = 1'b0;
    logic signed [15:0] i_hazard_angle = '0;
    logic [30:0]        i_hazard_distance = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [30:0]        o_linear_speed;
    logic signed [15:0] o_turn_rate;
    logic               o_goal_reached;
    logic [7:0]         o_avoid_level;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = REG_HEADING_GAIN;
    logic [31:0]        i_cfg_data = '0;

    int  fail_count, pending;
    bit  calm = 0;
    bit  hold_go = 0, hold_done = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    logic signed [31:0] last_gx = 0, last_gy = 0;

    always #5 i_clk = ~i_clk;

    go_to_goal_steering_controller_unit uut (.*);

    gtg_checker chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_ready   <= 1'b0;
            hold_left <= 400;
            hold_done <= 1;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_req(logic [1:0] act, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [15:0] hd, logic hf, logic signed [15:0] ha,
                            logic [30:0] hdist);
        if (!calm && $urandom_range(99) < 11) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= act;
        i_pos_x           <= x;
        i_pos_y           <= y;
        i_heading         <= hd;
        i_hazard_flag     <= hf;
        i_hazard_angle    <= ha;
        i_hazard_distance <= hdist;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drain all commands, then allow for a silent request still in flight
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] hg, logic [31:0] sg, logic [31:0] thr);
        logic [31:0] vals [4];
        vals = '{hg, sg, thr, $urandom()};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= k[1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base);
        return base + ($signed($urandom_range(0, 262143)) - 131072);
    endfunction

    task automatic random_req(bit burst);
        int r;
        logic signed [31:0] x, y;
        logic [30:0] hdist;
        r = $urandom_range(99);
        hdist = ($urandom_range(9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 200000));
        if (burst || (r >= 45 && r < 65)) begin
            // Hazard report, mostly with the flag set
            send_req(ACT_HAZARD, $urandom(), $urandom(), $urandom(),
                     burst || ($urandom_range(9) != 0), $urandom(), hdist);
            last_gx = 0;
            last_gy = 0;
        end else if (r < 45) begin
            // Pose near the goal or the origin, sometimes anywhere
            x = $urandom_range(1) ? last_gx : 0;
            y = $urandom_range(1) ? last_gy : 0;
            if ($urandom_range(3) == 0) begin
                x = $urandom(); y = $urandom();
            end else begin
                x = near(x); y = near(y);
            end
            send_req(ACT_POSE, x, y, $urandom(), $urandom(), $urandom(), $urandom());
        end else if (r < 80) begin
            x = ($urandom_range(4) == 0) ? $urandom() : $signed($urandom()) >>> 8;
            y = ($urandom_range(4) == 0) ? $urandom() : $signed($urandom()) >>> 8;
            send_req(ACT_GOAL, x, y, $urandom(), $urandom(), $urandom(), $urandom());
            last_gx = x;
            last_gy = y;
        end else if (r < 92) begin
            send_req(ACT_POSE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom());
        end else begin
            // Undefined action
            send_req(2'd3, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes and special cases at reset settings
        send_req(ACT_POSE, 0, 0, 0, 0, 0, 0);                          // zero offset
        send_req(ACT_POSE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 0, 0, 0);
        send_req(ACT_GOAL, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 0, 0, 0);
        send_req(ACT_POSE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh8000, 0, 0, 0);
        send_req(ACT_GOAL, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0);
        send_req(ACT_POSE, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF, 1, -1, '1);
        send_req(ACT_POSE, 32'sh7FFF_FFF0, 32'sh8000_0010, 0, 0, 0, 0);  // goal reached
        send_req(ACT_HAZARD, 0, 0, 0, 0, 16'sh4000, 31'd65536);         // flag clear
        send_req(ACT_HAZARD, 0, 0, 0, 1, 16'sh7FFF, 31'h7FFF_FFFF);
        send_req(ACT_POSE, 0, 0, 0, 0, 0, 0);
        send_req(ACT_GOAL, 12345, -6789, 100, 0, 0, 0);                 // ignored
        send_req(ACT_POSE, 1000, 1000, -100, 0, 0, 0);
        send_req(2'd3, '1, '1, '1, 1, '1, '1);
        send_req(ACT_HAZARD, 0, 0, 0, 1, 16'sh8000, 31'd0);
        send_req(ACT_HAZARD, 0, 0, 0, 1, 16'sd12868, 31'd30000);        // about pi/2
        send_req(ACT_HAZARD, 0, 0, 0, 1, -16'sd12868, 31'd30000);
        send_req(ACT_POSE, 0, -30000, 16'sd25000, 0, 0, 0);             // clears count
        send_req(ACT_GOAL, 32'sd400000, -32'sd400000, 0, 0, 0, 0);
        send_req(ACT_POSE, 0, 0, 16'sh8000, 0, 0, 0);
        send_req(ACT_POSE, 32'sd400000, -32'sd400000, 0, 0, 0, 0);

        // Random phases across register settings
        for (int n = 0; n < 1040; n++) begin
            if (n % 200 == 0) begin
                settle();
                case (n / 200)
                    0: write_regs(32'hFFFF_0000, 32'hFFFF_0000, 32'h8000_0000);
                    1: write_regs(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                    2: write_regs(256, 256, 65536);
                    default: write_regs($urandom(), $urandom(), $urandom_range(0, 1 << 20));
                endcase
            end
            calm = (n >= 300 && n < 420);
            // long hold-off while mixed requests keep coming, so results back up
            if (n == 750) hold_go <= 1;
            random_req(n >= 440 && n < 700);
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
